// File: rtl/bmprle_pkg.sv
package bmprle_pkg;

  // Parameter defaults
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF    = 12;

  // Configuration registers
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] LINE_WIDTH_RST   = 13'd480;
  localparam logic [CFG_DATA_BITS-1:0] IMAGE_HEIGHT_RST = 13'd320;

  // Item operations
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_RUN = 2'd0;
  localparam kind_t KIND_EOL = 2'd1;
  localparam kind_t KIND_EOI = 2'd2;

  // Escape codes after a zero first byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 48;
  localparam int OUT_FIELD_BITS = 12;

  function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: rtl/bmp_rle8_palette_decoder.sv
// Channel | Ports                        | Content
// --------+------------------------------+---------------------------------------------
// input   | in_tvalid/in_tready          | tuser: operation; tdata: byte, slot, r, g, b
// output  | out_tvalid/out_tready        | tuser: kind; tdata: x, row, length, colour
// config  | cfg_wr_en/cfg_index/cfg_wdata| line_width (0), image_height (1)
//
// One item is accepted every cycle while the output side keeps up.
// Each result passes through the registered palette read stage and then
// the output register.
// Reset (rst_n low, synchronous) returns the parser to the first byte of a pair,
// row to the top line and the registers to width 480, height 320; the palette
// holds whatever was last written.
// With the output stalled, one more result waits in the palette read stage;
// in_tready drops while that stage is full and the output cannot take it.
module bmp_rle8_palette_decoder
  import bmprle_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] data_byte, [15:8] palette_slot, [23:16] red, [31:24] green, [39:32] blue
  input  logic [bmprle_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // [0] operation
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [11:0] x_start, [23:12] row, [31:24] run_length, [47:32] color
  output logic [bmprle_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // [1:0] kind
  output bmprle_pkg::kind_t                     out_tuser,
  input  logic                                  cfg_wr_en,
  input  logic [bmprle_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bmprle_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int WW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
  localparam logic [WW-1:0] COL_LIM = WW'(1) << COORD_BITS;
  localparam logic [8:0]    PAL_LIM = 9'(PALETTE_DEPTH);

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_DX     = 3'd2;
  localparam logic [2:0] PH_DY     = 3'd3;
  localparam logic [2:0] PH_LIT    = 3'd4;
  localparam logic [2:0] PH_PAD    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  function automatic logic [CB:0] top_of(input logic [CFG_DATA_BITS-1:0] h);
    logic [WW-1:0] hw;
    hw = WW'(h);
    if (hw > COL_LIM) top_of = (CB+1)'(COL_LIM - WW'(1));
    else              top_of = (CB+1)'(hw - WW'(1));
  endfunction

  // Input fields
  logic [7:0] data_byte, palette_slot, red, green, blue;
  assign data_byte    = in_tdata[7:0];
  assign palette_slot = in_tdata[15:8];
  assign red          = in_tdata[23:16];
  assign green        = in_tdata[31:24];
  assign blue         = in_tdata[39:32];

  // Registers
  logic [CFG_DATA_BITS-1:0] line_width_r;
  logic [2:0]               phase_r, phase_nxt;
  logic [7:0]               first_r, first_nxt;
  logic [7:0]               lit_r, lit_nxt;
  logic                     pad_r, pad_nxt;
  logic [CB-1:0]            col_r, col_nxt;
  logic [CB:0]              row_r, row_nxt;   // two's complement, floors at -1

  logic                     s1_valid_r;
  kind_t                    s1_kind_r;
  logic [OUT_FIELD_BITS-1:0] s1_x_r, s1_row_r;
  logic [7:0]               s1_len_r;
  logic                     s1_zero_r;
  logic [15:0]              pal_rd_r;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_tdata_r;
  kind_t                    out_tuser_r;

  logic [15:0] pal_mem [PALETTE_DEPTH];

  // Handshake
  logic out_free, s1_go, in_fire, data_fire, pal_wr;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign data_fire = in_fire && (in_tuser == OP_DATA) && (phase_r != PH_DONE);
  assign pal_wr    = in_fire && (in_tuser == OP_PALETTE) && ({1'b0, palette_slot} < PAL_LIM);

  // Column and row arithmetic shared by encoded runs, absolute runs and deltas
  logic [7:0]    cnt;
  logic [CB:0]   col_sum;
  logic [CB-1:0] col_sat;
  logic [WW-1:0] xw, lww, room, rw, row_sx, dy_diff;
  logic [7:0]    run_len;
  logic          row_neg;

  always_comb begin
    cnt     = (phase_r == PH_LIT) ? 8'd1 : (phase_r == PH_DX) ? data_byte : first_r;
    col_sum = {1'b0, col_r} + (CB+1)'(cnt);
    col_sat = col_sum[CB] ? '1 : col_sum[CB-1:0];
    xw      = WW'(col_r);
    lww     = WW'(line_width_r);
    room    = lww - xw;
    if (xw < lww) run_len = (room > WW'(cnt)) ? cnt : room[7:0];
    else          run_len = 8'd0;
    row_neg = row_r[CB];
    rw      = WW'(row_r[CB-1:0]);
    row_sx  = {{(WW-CB-1){row_r[CB]}}, row_r};
    dy_diff = row_sx - WW'(data_byte);
  end

  // Parser
  logic          emit, rd_pal;
  kind_t         emit_kind;
  logic [7:0]    emit_len;
  logic [OUT_FIELD_BITS-1:0] emit_row;

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    lit_nxt   = lit_r;
    pad_nxt   = pad_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    emit      = 1'b0;
    rd_pal    = 1'b0;
    emit_kind = KIND_RUN;
    emit_len  = run_len;
    emit_row  = rw[OUT_FIELD_BITS-1:0];
    case (phase_r)
      PH_FIRST: begin
        first_nxt = data_byte;
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        phase_nxt = PH_FIRST;
        if (first_r != 8'd0) begin
          col_nxt = col_sat;
          emit    = !row_neg;
          rd_pal  = 1'b1;
        end else begin
          case (data_byte)
            ESC_EOL: begin
              emit      = !row_neg;
              emit_kind = KIND_EOL;
              emit_len  = 8'd0;
              col_nxt   = '0;
              if (!row_neg) row_nxt = row_r - (CB+1)'(1);
            end
            ESC_EOI: begin
              phase_nxt = PH_DONE;
              emit      = 1'b1;
              emit_kind = KIND_EOI;
              emit_len  = 8'd0;
              if (row_neg) emit_row = '0;
            end
            ESC_DELTA: phase_nxt = PH_DX;
            default: begin
              lit_nxt   = data_byte;
              pad_nxt   = data_byte[0];
              phase_nxt = PH_LIT;
            end
          endcase
        end
      end
      PH_DX: begin
        col_nxt   = col_sat;
        phase_nxt = PH_DY;
      end
      PH_DY: begin
        // floor at -1
        if (dy_diff[WW-1] && (dy_diff != '1)) row_nxt = '1;
        else                                  row_nxt = dy_diff[CB:0];
        phase_nxt = PH_FIRST;
      end
      PH_LIT: begin
        col_nxt = col_sat;
        emit    = !row_neg;
        rd_pal  = 1'b1;
        lit_nxt = lit_r - 8'd1;
        if (lit_r == 8'd1) phase_nxt = pad_r ? PH_PAD : PH_FIRST;
      end
      PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_nxt = PH_FIRST;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Palette store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pal_wr) pal_mem[palette_slot[PW-1:0]] <= rgb565(red, green, blue);
    if (data_fire && emit) pal_rd_r <= pal_mem[data_byte[PW-1:0]];
  end

  // Parser state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      phase_r        <= PH_FIRST;
      first_r        <= 8'd0;
      lit_r          <= 8'd0;
      pad_r          <= 1'b0;
      col_r          <= '0;
      row_r          <= top_of(IMAGE_HEIGHT_RST);
    end else begin
      if (data_fire) begin
        phase_r <= phase_nxt;
        first_r <= first_nxt;
        lit_r   <= lit_nxt;
        pad_r   <= pad_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LINE_WIDTH:   line_width_r <= cfg_wdata;
          REG_IMAGE_HEIGHT: row_r        <= top_of(cfg_wdata);
          default: line_width_r <= line_width_r;
        endcase
      end
    end
  end

  // Palette read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= data_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire && emit) begin
      s1_kind_r <= emit_kind;
      s1_x_r    <= (emit_kind == KIND_RUN) ? xw[OUT_FIELD_BITS-1:0] : '0;
      s1_row_r  <= emit_row;
      s1_len_r  <= emit_len;
      // marks and indices beyond the palette give colour 0
      s1_zero_r <= !rd_pal || ({1'b0, data_byte} >= PAL_LIM);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_tuser_r <= s1_kind_r;
      out_tdata_r <= {(s1_zero_r ? 16'd0 : pal_rd_r), s1_len_r, s1_row_r, s1_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: tb/sv/bmp_rle8_palette_decoder_test.sv
module bmp_rle8_palette_decoder_test;
  import bmprle_pkg::*;

  localparam int COORD_TOP     = 4095;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_LIMIT  = 40;

  typedef enum logic [2:0] {
    ST_FIRST, ST_SECOND, ST_DX, ST_DY, ST_LITERAL, ST_PAD, ST_DONE
  } parse_st_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] x_start;
    logic [11:0] row;
    logic [7:0]  length;
    logic [15:0] color;
  } pixel_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  kind_t                    out_tuser;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  bmp_rle8_palette_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Decoder mirror
  logic [12:0] line_w;
  parse_st_t   st;
  logic [7:0]  lead_byte;
  logic [7:0]  lit_left;
  logic        pad_due;
  int          col;
  int          cur_row;
  logic [15:0] pal [256];
  bit          pal_set [256];

  pixel_result_t pending_results[$];

  int errors = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int run_results = 0;
  int eol_results = 0;
  int eoi_results = 0;
  int clipped_runs = 0;
  int dropped_runs = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;
  bit eoi_allowed = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int top_row(logic [12:0] h);
    return (h > COORD_TOP + 1) ? COORD_TOP : int'(h) - 1;
  endfunction

  // Clip at the current column, then advance it with saturation.
  function automatic bit run_result(int count, logic [15:0] color, output pixel_result_t r);
    int x;
    int len;
    x = col;
    col = (col + count > COORD_TOP) ? COORD_TOP : col + count;
    r = '0;
    if (cur_row < 0) begin
      dropped_runs++;
      return 0;
    end
    len = 0;
    if (x < int'(line_w)) len = (int'(line_w) - x < count) ? int'(line_w) - x : count;
    if (len < count) clipped_runs++;
    r.kind    = KIND_RUN;
    r.x_start = 12'(x);
    r.row     = 12'(cur_row);
    r.length  = 8'(len);
    r.color   = color;
    return 1;
  endfunction

  function automatic bit decode_step(logic op, logic [IN_DATA_BITS-1:0] d,
                                     output pixel_result_t r);
    logic [7:0] b;
    bit hit;
    b = d[7:0];
    r = '0;
    if (op == OP_PALETTE) begin
      pal[d[15:8]]     = {d[23:19], d[31:26], d[39:35]};
      pal_set[d[15:8]] = 1'b1;
      return 0;
    end
    case (st)
      ST_FIRST: begin
        lead_byte = b;
        st = ST_SECOND;
        return 0;
      end
      ST_SECOND: begin
        st = ST_FIRST;
        if (lead_byte != 8'd0) return run_result(int'(lead_byte), pal[b], r);
        if (b == ESC_EOL) begin
          hit = 0;
          if (cur_row >= 0) begin
            r.kind = KIND_EOL;
            r.row  = 12'(cur_row);
            hit = 1;
            cur_row--;
          end
          col = 0;
          return hit;
        end
        if (b == ESC_EOI) begin
          st = ST_DONE;
          r.kind = KIND_EOI;
          r.row  = (cur_row >= 0) ? 12'(cur_row) : 12'd0;
          return 1;
        end
        if (b == ESC_DELTA) begin
          st = ST_DX;
          return 0;
        end
        lit_left = b;
        pad_due  = b[0];
        st = ST_LITERAL;
        return 0;
      end
      ST_DX: begin
        col = (col + int'(b) > COORD_TOP) ? COORD_TOP : col + int'(b);
        st = ST_DY;
        return 0;
      end
      ST_DY: begin
        cur_row = cur_row - int'(b);
        if (cur_row < -1) cur_row = -1;
        st = ST_FIRST;
        return 0;
      end
      ST_LITERAL: begin
        hit = run_result(1, pal[b], r);
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) st = pad_due ? ST_PAD : ST_FIRST;
        return hit;
      end
      ST_PAD: begin
        pad_due = 1'b0;
        st = ST_FIRST;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_slot();
    logic [7:0] s;
    s = 8'($urandom);
    for (int i = 0; i < 256 && !pal_set[s]; i++) s++;
    return s;
  endfunction

  // Steer a data byte away from unwritten palette entries and, until the
  // closing test, away from the end-of-image escape.
  function automatic logic [7:0] safe_byte(logic [7:0] b);
    bit reads_pal;
    reads_pal = (st == ST_SECOND && lead_byte != 8'd0) || st == ST_LITERAL;
    if (reads_pal && !pal_set[b]) return pick_slot();
    if (st == ST_SECOND && lead_byte == 8'd0 && b == ESC_EOI && !eoi_allowed) return ESC_EOL;
    return b;
  endfunction

  task automatic send_item(logic op, logic [IN_DATA_BITS-1:0] d);
    int gap;
    pixel_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (decode_step(op, d, r)) pending_results.push_back(r);
  endtask

  task automatic send_data(logic [7:0] b);
    send_item(OP_DATA, {32'($urandom), safe_byte(b)});
  endtask

  task automatic send_palette(logic [7:0] slot, logic [7:0] red, logic [7:0] green,
                              logic [7:0] blue);
    send_item(OP_PALETTE, {blue, green, red, slot, 8'($urandom)});
  endtask

  task automatic send_encoded(logic [7:0] count, logic [7:0] index);
    send_data(count);
    send_data(index);
  endtask

  task automatic send_eol();
    send_data(8'd0);
    send_data(ESC_EOL);
  endtask

  task automatic send_delta(logic [7:0] dx, logic [7:0] dy);
    send_data(8'd0);
    send_data(ESC_DELTA);
    send_data(dx);
    send_data(dy);
  endtask

  task automatic send_absolute(logic [7:0] n);
    send_data(8'd0);
    send_data(n);
    repeat (n) send_data(8'($urandom));
    if (n[0]) send_data(8'($urandom));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_writes++;
    if (idx == REG_LINE_WIDTH) begin
      line_w = v;
    end else begin
      cur_row = top_row(v);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_geometry(logic [12:0] w, logic [12:0] h);
    wait_results_done();
    write_reg(REG_LINE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_encoded(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40)),
                   8'($urandom));
    end else if (pick < 50) begin
      send_eol();
    end else if (pick < 60) begin
      send_delta(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)),
                 ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
    end else if (pick < 78) begin
      send_absolute(($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 255))
                                                : 8'($urandom_range(3, 12)));
    end else if (pick < 88) begin
      send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      // broken sequence: stray bytes knock the pairing out of step
      repeat ($urandom_range(1, 3)) send_data(8'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    send_palette(8'd0, 8'd0, 8'd0, 8'd0);
    send_palette(8'd255, 8'd255, 8'd255, 8'd255);
    send_palette(8'hA5, 8'hF8, 8'h03, 8'h07);
    // reset geometry: one full run, then one crossing the line end
    send_encoded(8'd255, 8'd255);
    send_encoded(8'd255, 8'hA5);
    send_encoded(8'd0, 8'd0);
    send_eol();
    send_delta(8'd5, 8'd1);
    send_absolute(8'd3);
    send_absolute(8'd4);
  endtask

  task automatic test_palette_fill();
    for (int s = 0; s < 256; s++)
      send_palette(8'(s), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_column_saturation();
    // heights above the coordinate range start on the top row
    set_geometry(13'd8191, 13'd8191);
    repeat (17) send_encoded(8'd255, pick_slot());
    send_encoded(8'd7, pick_slot());
    send_delta(8'd255, 8'd0);
    send_encoded(8'd1, pick_slot());
    wait_results_done();
    write_reg(REG_LINE_WIDTH, 13'd4096);
    send_encoded(8'd3, pick_slot());
    send_eol();
  endtask

  task automatic test_random_stream(logic [12:0] w, logic [12:0] h, int n_items, bit burst);
    int stop_at;
    int neg_cmds;
    bit paused;
    set_geometry(w, h);
    no_gaps  = burst;
    stop_at  = items_sent + n_items;
    neg_cmds = 0;
    paused   = 0;
    while (items_sent < stop_at) begin
      random_command();
      if (cur_row < 0) neg_cmds++;
      // reload the top row once a stretch of dropped output has gone by
      if (neg_cmds > 8 && st == ST_FIRST) begin
        wait_results_done();
        write_reg(REG_IMAGE_HEIGHT, h);
        neg_cmds = 0;
      end
      if (!paused && items_sent >= stop_at - n_items / 2) begin
        wait_results_done();
        paused = 1;
      end
    end
    while (st != ST_FIRST)
      send_data((st == ST_DX || st == ST_DY) ? 8'd0 : 8'($urandom));
    no_gaps = 0;
  endtask

  task automatic test_end_of_image();
    set_geometry(13'd480, 13'd3);
    send_encoded(8'd4, pick_slot());
    send_delta(8'd0, 8'd200);
    send_encoded(8'd10, pick_slot());
    send_eol();
    send_absolute(8'd3);
    eoi_allowed = 1;
    send_data(8'd0);
    send_data(ESC_EOI);
    // data bytes after the end mark are ignored; palette writes still land
    repeat (16) send_data(8'($urandom));
    send_palette(8'd1, 8'($urandom), 8'($urandom), 8'($urandom));
    send_encoded(8'd5, 8'd1);
    send_data(8'd0);
    send_data(ESC_EOI);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result sink: random back-pressure unless in a burst, compare against the oldest expectation
  initial begin
    pixel_result_t got;
    pixel_result_t want;
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = {out_tuser, out_tdata[11:0], out_tdata[23:12], out_tdata[31:24], out_tdata[47:32]};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result: expected none, actual kind %0d x %0d row %0d",
                   $time, got.kind, got.x_start, got.row);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("x_start", want.x_start, got.x_start);
        check_field("row", want.row, got.row);
        check_field("run_length", want.length, got.length);
        check_field("color", want.color, got.color);
        case (want.kind)
          KIND_RUN: run_results++;
          KIND_EOL: eol_results++;
          default:  eoi_results++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_DATA;
    cfg_wr_en = 1'b0;
    cfg_index = REG_LINE_WIDTH;
    cfg_wdata = '0;
    line_w    = LINE_WIDTH_RST;
    st        = ST_FIRST;
    lead_byte = 8'd0;
    lit_left  = 8'd0;
    pad_due   = 1'b0;
    col       = 0;
    cur_row   = top_row(IMAGE_HEIGHT_RST);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_palette_fill();
    test_column_saturation();
    test_random_stream(13'd480, 13'd320, 300, 0);
    test_random_stream(13'd1, 13'd4096, 200, 0);
    test_random_stream(13'd4096, 13'd4096, 250, 0);
    test_random_stream(13'd8191, 13'd64, 200, 1);
    test_random_stream(13'd0, 13'd16, 120, 0);
    test_random_stream(13'($urandom_range(2, 600)), 13'($urandom_range(2, 300)), 200, 0);
    test_random_stream(13'd200, 13'd0, 60, 0);
    test_random_stream(13'd32, 13'd1, 60, 0);
    test_end_of_image();
    wait_results_done();

    $display("Drove %0d items with %0d register writes, widths 0 to 8191, heights 0 to 8191",
             items_sent, cfg_writes);
    $display("Checked %0d runs (%0d clipped, %0d dropped off the image),",
             run_results, clipped_runs, dropped_runs);
    $display("%0d line ends and %0d image end", eol_results, eoi_results);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: bmp_rle8_palette_decoder.f
rtl/bmprle_pkg.sv
rtl/bmp_rle8_palette_decoder.sv
tb/sv/bmp_rle8_palette_decoder_test.sv
